>>> rtl/pgwalk_pkg.sv
// Package for the four-level page table walker: types, status codes and
// bit positions of a table entry. No dependencies.
`timescale 1ns / 1ps

package pgwalk_pkg;

  // Geometry of one table page and of the virtual address.
  localparam int unsigned WordsPerPage = 512;
  localparam int unsigned LevelBits    = 9;
  localparam int unsigned PageShift    = 12;
  localparam int unsigned VaWidth      = 48;
  localparam int unsigned PaWidth      = 52;
  localparam int unsigned EntryWidth   = 64;
  localparam int unsigned FrameWidth   = PaWidth - PageShift;

  // Bit positions inside a table entry.
  localparam int unsigned BitPresent = 0;
  localparam int unsigned BitHuge    = 7;

  // Item kind carried on the input side.
  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_XLATE = 1'b1
  } func_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_PRESENT = 2'd1,
    ST_HUGE        = 2'd2,
    ST_BEYOND      = 2'd3
  } status_e;

  // Walker control states.
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_HOLD
  } state_e;

  // The 9-bit table index for a level; level 3 is the top, 0 the leaf.
  function automatic logic [LevelBits-1:0] level_index(input logic [VaWidth-1:0] va,
                                                       input logic [1:0]         level);
    logic [LevelBits-1:0] idx;
    case (level)
      2'd0:    idx = va[20:12];
      2'd1:    idx = va[29:21];
      2'd2:    idx = va[38:30];
      2'd3:    idx = va[47:39];
      default: idx = va[47:39];
    endcase
    return idx;
  endfunction

endpackage

>>> rtl/four_level_page_table_walk_core.sv
// Top level of the four-level page table walker: control state machine,
// root register and output register. Depends on pgwalk_pkg and pgwalk_ram.
`timescale 1ns / 1ps

// Usage
// Items enter on the s_axis channel. tuser selects a table write (0) or a
// translation (1). Every item produces exactly one result on m_axis, holding
// the physical address and a status code (ok, not present, huge entry, table
// beyond store). The user must set the root table page through cfg_we_i /
// cfg_wdata_i only while the walker is idle; the block does not enforce it.
// Flow: a write finishes as it is accepted; a translation reads the table
// RAM once per table level, and each of the four reads depends on the entry
// returned by the previous one. The walker takes no new item until a walk
// ends; a walk that fails early ends sooner.
// The result lands in an output register; the next item is accepted while it
// waits. If the receiver stalls and a second result is ready, the walker
// holds it and stops accepting until the output register drains.
// Reset: after rst_ni is released the table RAM is cleared one word per
// cycle, all TABLE_PAGES * 512 words, during which s_axis_tready is low.

module four_level_page_table_walk_core
  import pgwalk_pkg::*;
#(
  parameter int unsigned TABLE_PAGES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration: root table page.
  input  logic         cfg_we_i,
  input  logic [3:0]   cfg_wdata_i,
  // Input items.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // word_index [12:0], word_value [76:13], virt_addr [124:77], zero [127:125]
  input  logic [127:0] s_axis_tdata,
  // func [0]
  input  logic [0:0]   s_axis_tuser,
  // Results.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // phys_addr [51:0], status [53:52], zero [55:54]
  output logic [55:0]  m_axis_tdata
);

  localparam int unsigned StoreWords = TABLE_PAGES * WordsPerPage;
  localparam int unsigned AddrWidth  = $clog2(StoreWords);
  localparam int unsigned PageWidth  = AddrWidth - LevelBits;
  localparam logic [AddrWidth-1:0] LastAddr = AddrWidth'(StoreWords - 1);

  // Input field unpacking.
  logic [12:0]         in_word_index;
  logic [63:0]         in_word_value;
  logic [VaWidth-1:0]  in_virt_addr;
  func_e               in_func;

  assign in_word_index = s_axis_tdata[12:0];
  assign in_word_value = s_axis_tdata[76:13];
  assign in_virt_addr  = s_axis_tdata[124:77];
  assign in_func       = func_e'(s_axis_tuser[0]);

  // Registers.
  state_e              state_q, state_d;
  logic [1:0]          level_q, level_d;
  logic [VaWidth-1:0]  va_q, va_d;
  logic [AddrWidth-1:0] clr_q, clr_d;
  logic [3:0]          root_q;
  logic                m_valid_q, m_valid_d;
  logic [PaWidth-1:0]  m_phys_q;
  status_e             m_status_q;
  logic [PaWidth-1:0]  res_phys_q, res_phys_d;
  status_e             res_status_q, res_status_d;

  // RAM ports.
  logic                 ram_we;
  logic [AddrWidth-1:0] ram_waddr;
  logic [EntryWidth-1:0] ram_wdata;
  logic                 ram_re;
  logic [AddrWidth-1:0] ram_raddr;
  logic [EntryWidth-1:0] ram_rdata;

  // Walk completion and output loading.
  logic                fin;
  logic [PaWidth-1:0]  fin_phys;
  status_e             fin_status;
  logic                out_free;
  logic                load_out;
  logic [PaWidth-1:0]  load_phys;
  status_e             load_status;
  logic [FrameWidth-1:0] next_frame;

  assign out_free   = !m_valid_q || m_axis_tready;
  assign next_frame = ram_rdata[PaWidth-1:PageShift];

  pgwalk_ram #(
    .Width(EntryWidth),
    .Depth(StoreWords)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Next state, RAM access and result selection.
  always_comb begin
    state_d      = state_q;
    level_d      = level_q;
    va_d         = va_q;
    clr_d        = clr_q;
    res_phys_d   = res_phys_q;
    res_status_d = res_status_q;
    ram_we       = 1'b0;
    ram_waddr    = clr_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    fin          = 1'b0;
    fin_phys     = '0;
    fin_status   = ST_OK;
    load_out     = 1'b0;
    load_phys    = res_phys_q;
    load_status  = res_status_q;

    case (state_q)
      S_CLEAR: begin
        // Zero one word per cycle after reset.
        ram_we = 1'b1;
        if (clr_q == LastAddr) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          va_d = in_virt_addr;
          if (in_func == FUNC_WRITE) begin
            // Writes beyond the store are dropped but still answered.
            ram_we    = (32'(in_word_index) < 32'(StoreWords));
            ram_waddr = AddrWidth'(in_word_index);
            ram_wdata = in_word_value;
            fin       = 1'b1;
          end else if (32'(root_q) >= 32'(TABLE_PAGES)) begin
            fin        = 1'b1;
            fin_status = ST_BEYOND;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = {PageWidth'(root_q), level_index(in_virt_addr, 2'd3)};
            level_d   = 2'd3;
            state_d   = S_LOOKUP;
          end
        end
      end
      S_LOOKUP: begin
        // Check the entry just read and either finish or descend.
        if (!ram_rdata[BitPresent]) begin
          fin        = 1'b1;
          fin_status = ST_NOT_PRESENT;
        end else if (level_q == 2'd0) begin
          fin      = 1'b1;
          fin_phys = {next_frame, va_q[PageShift-1:0]};
        end else if (ram_rdata[BitHuge]) begin
          fin        = 1'b1;
          fin_status = ST_HUGE;
        end else if (next_frame >= FrameWidth'(TABLE_PAGES)) begin
          fin        = 1'b1;
          fin_status = ST_BEYOND;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = {PageWidth'(next_frame), level_index(va_q, level_q - 2'd1)};
          level_d   = level_q - 2'd1;
        end
      end
      S_HOLD: begin
        // A finished result waits for the output register to drain.
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Hand a finished result to the output register, or park it.
    if (fin) begin
      if (out_free) begin
        load_out    = 1'b1;
        load_phys   = fin_phys;
        load_status = fin_status;
        state_d     = S_IDLE;
      end else begin
        res_phys_d   = fin_phys;
        res_status_d = fin_status;
        state_d      = S_HOLD;
      end
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);

  // Output valid tracking.
  always_comb begin
    if (load_out) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      level_q   <= '0;
      clr_q     <= '0;
      root_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      level_q   <= level_d;
      clr_q     <= clr_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    va_q         <= va_d;
    res_phys_q   <= res_phys_d;
    res_status_q <= res_status_d;
    if (load_out) begin
      m_phys_q   <= load_phys;
      m_status_q <= load_status;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, m_status_q, m_phys_q};

endmodule

>>> rtl/pgwalk_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module pgwalk_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> test/testbench.sv
// Self-checking testbench for four_level_page_table_walk_core: directed rows, then random
// table chains and noise under several root pages, with random stalls on both streams.
// Depends on pgwalk_pkg and the walker RTL only.
`timescale 1ns / 1ps

module testbench;
  import pgwalk_pkg::*;

  localparam int unsigned TablePages  = 16;
  localparam int unsigned StoreWords  = TablePages * WordsPerPage;
  localparam int          NumPhases   = 6;
  localparam int          PhaseItems  = 305;
  localparam int          CfgSettle   = 8;
  localparam int          TailCycles  = 20;
  localparam int          LongHold    = 300;
  localparam int          HoldAfter   = 400;
  localparam int          PrintLimit  = 100;

  // One result of the walker.
  typedef struct packed {
    logic [PaWidth-1:0] phys;
    status_e            status;
  } walk_result_t;

  // One row of the directed stimulus; want is used only where typed is set.
  typedef struct packed {
    func_e        kind;
    logic [12:0]  widx;
    logic [63:0]  wval;
    logic [47:0]  va;
    logic         typed;
    walk_result_t want;
  } stim_row_t;

  // Ways a random table chain is damaged before it is walked.
  typedef enum int {
    CHAIN_CLEAN,
    CHAIN_ABSENT,
    CHAIN_HUGE,
    CHAIN_BEYOND,
    CHAIN_GAP
  } chain_fault_e;

  localparam walk_result_t WriteAck = '{phys: '0, status: ST_OK};

  // Directed rows. The store holds zeros after the clearing pass and the root page is 0.
  localparam stim_row_t DirectedRows [22] = '{
    // Empty store: the top-level entry is absent.
    '{FUNC_XLATE, 13'd0,    64'd0, 48'h0000_0000_0000, 1'b1, '{52'd0, ST_NOT_PRESENT}},
    '{FUNC_XLATE, 13'h1FFF, 64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1,
      '{52'd0, ST_NOT_PRESENT}},
    // Build the chain root -> page 1 -> page 2 -> page 3 for index 0 at every level.
    '{FUNC_WRITE, 13'd0,    64'h0000_0000_0000_1001, 48'd0, 1'b1, WriteAck},
    '{FUNC_WRITE, 13'h1FFF, 64'hFFFF_FFFF_FFFF_FFFF, 48'd0, 1'b1, WriteAck},
    '{FUNC_WRITE, 13'd512,  64'h0000_0000_0000_2001, 48'd0, 1'b1, WriteAck},
    '{FUNC_WRITE, 13'd1024, 64'h0000_0000_0000_3001, 48'd0, 1'b1, WriteAck},
    // Leaf with every bit set: the huge bit of a leaf is ignored, the frame is the largest.
    '{FUNC_WRITE, 13'd1536, 64'hFFFF_FFFF_FFFF_FFFF, 48'd0, 1'b1, WriteAck},
    '{FUNC_XLATE, 13'd0, 64'd0, 48'h0000_0000_0ABC, 1'b1, '{52'hF_FFFF_FFFF_FABC, ST_OK}},
    // Leaf entry that is not present.
    '{FUNC_XLATE, 13'd0, 64'd0, 48'h0000_0000_1000, 1'b1, '{52'd0, ST_NOT_PRESENT}},
    // Huge entry at the third level.
    '{FUNC_WRITE, 13'd513,  64'h0000_0000_0000_5081, 48'd0, 1'b1, WriteAck},
    '{FUNC_XLATE, 13'd0, 64'd0, 48'h0000_4000_0000, 1'b1, '{52'd0, ST_HUGE}},
    // Second-level entry that points one page past the store.
    '{FUNC_WRITE, 13'd1025, 64'h0000_0000_0001_0001, 48'd0, 1'b1, WriteAck},
    '{FUNC_XLATE, 13'd0, 64'd0, 48'h0000_0020_0000, 1'b1, '{52'd0, ST_BEYOND}},
    // Top-level entry with the largest table pointer.
    '{FUNC_WRITE, 13'd2,    64'h000F_FFFF_FFFF_F001, 48'd0, 1'b1, WriteAck},
    '{FUNC_XLATE, 13'd0, 64'd0, 48'h0100_0000_0000, 1'b1, '{52'd0, ST_BEYOND}},
    // Huge entry at the top level.
    '{FUNC_WRITE, 13'd3,    64'h0000_0000_0000_1081, 48'd0, 1'b1, WriteAck},
    '{FUNC_XLATE, 13'd0, 64'd0, 48'h0180_0000_0000, 1'b1, '{52'd0, ST_HUGE}},
    '{FUNC_XLATE, 13'd0, 64'd0, 48'h0080_0000_0000, 1'b1, '{52'd0, ST_NOT_PRESENT}},
    // Top-level entry pointing back at the root page, with the upper flag bit set.
    '{FUNC_WRITE, 13'd1,    64'h8000_0000_0000_0001, 48'd0, 1'b1, WriteAck},
    '{FUNC_XLATE, 13'd0, 64'd0, 48'h0080_0000_0FFF, 1'b0, WriteAck},
    // Clear the leaf again.
    '{FUNC_WRITE, 13'd1536, 64'd0, 48'd0, 1'b1, WriteAck},
    '{FUNC_XLATE, 13'd0, 64'd0, 48'h0000_0000_0000, 1'b1, '{52'd0, ST_NOT_PRESENT}}
  };

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [3:0]   cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic [0:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [55:0]  m_axis_tdata;

  // Mirror of the walker state.
  logic [63:0]  table_mirror [StoreWords];
  logic [3:0]   root_mirror;

  walk_result_t walk_result_q [$];
  walk_result_t seen_res;
  walk_result_t want_res;
  int           error_count;
  int           results_taken;
  int           items_sent;
  int           burst_left;

  four_level_page_table_walk_core #(
    .TABLE_PAGES(TablePages)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Applies one item to the mirror and returns the result the walker must give.
  function automatic walk_result_t walk_outcome(input func_e kind, input logic [12:0] widx,
                                                input logic [63:0] wval,
                                                input logic [47:0] va);
    walk_result_t res;
    logic [39:0]  page;
    logic [63:0]  entry;
    logic [8:0]   idx;
    res = '{phys: '0, status: ST_OK};
    if (kind == FUNC_WRITE) begin
      // With 16 pages every 13-bit word index lies inside the store.
      table_mirror[widx] = wval;
      return res;
    end
    page = {36'd0, root_mirror};
    for (int lvl = 4; lvl >= 1; lvl--) begin
      if (page >= 40'(TablePages)) begin
        res.status = ST_BEYOND;
        return res;
      end
      idx   = va[PageShift + LevelBits * (lvl - 1) +: LevelBits];
      entry = table_mirror[{page[3:0], idx}];
      if (!entry[BitPresent]) begin
        res.status = ST_NOT_PRESENT;
        return res;
      end
      // The leaf is not tested for the huge bit.
      if (lvl == 1) begin
        res.phys = {entry[51:12], va[11:0]};
        return res;
      end
      if (entry[BitHuge]) begin
        res.status = ST_HUGE;
        return res;
      end
      page = entry[51:12];
    end
    res.status = ST_NOT_PRESENT;
    return res;
  endfunction

  // Table entry with random flag bits around the given frame, present and huge bits.
  function automatic logic [63:0] table_entry(input logic [39:0] frame, input logic present,
                                              input logic huge);
    logic [63:0] e;
    e             = {$urandom, $urandom};
    e[51:12]      = frame;
    e[BitPresent] = present;
    e[BitHuge]    = huge;
    return e;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < PrintLimit) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // Offers one item in bursts with random gaps, and records its result on transfer.
  task automatic send_item(input func_e kind, input logic [12:0] widx, input logic [63:0] wval,
                           input logic [47:0] va, input logic typed = 1'b0,
                           input walk_result_t want = '0);
    walk_result_t pred;
    int           gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {3'b000, va, wval, widx};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = walk_outcome(kind, widx, wval, va);
    walk_result_q.push_back(typed ? want : pred);
    items_sent++;
  endtask

  // Stops offering items and waits until every result has been taken.
  task automatic drain_walker();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (walk_result_q.size() != 0) @(posedge clk_i);
  endtask

  // Writes the root page while the walker is idle.
  task automatic set_root(input logic [3:0] value);
    drain_walker();
    repeat (CfgSettle) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    root_mirror = value;
  endtask

  // Writes a four-level chain for a random address, maybe damaged, then walks it.
  task automatic run_chain_episode();
    logic [47:0]  va;
    logic [3:0]   here;
    logic [3:0]   nxt;
    logic [39:0]  frame;
    logic         present;
    logic         huge;
    chain_fault_e fault;
    int           fault_lvl;
    int           pick;
    int           walks;
    va        = 48'({$urandom, $urandom});
    pick      = $urandom_range(0, 9);
    fault     = (pick < 6) ? CHAIN_CLEAN : chain_fault_e'(pick - 5);
    fault_lvl = (fault == CHAIN_ABSENT || fault == CHAIN_GAP) ? $urandom_range(1, 4)
                                                              : $urandom_range(2, 4);
    here      = root_mirror;
    for (int lvl = 4; lvl >= 1; lvl--) begin
      nxt     = 4'($urandom_range(0, TablePages - 1));
      frame   = (lvl == 1) ? 40'({$urandom, $urandom}) : {36'd0, nxt};
      present = !(fault == CHAIN_ABSENT && lvl == fault_lvl);
      huge    = (lvl == 1) ? 1'($urandom_range(0, 1))
                           : (fault == CHAIN_HUGE && lvl == fault_lvl);
      if (fault == CHAIN_BEYOND && lvl == fault_lvl) begin
        frame = ($urandom_range(0, 1) == 1) ? 40'(TablePages + $urandom_range(0, 15))
                                            : 40'({$urandom, $urandom});
        if (frame < 40'(TablePages)) frame = frame + 40'(TablePages);
      end
      if (!(fault == CHAIN_GAP && lvl == fault_lvl)) begin
        send_item(FUNC_WRITE, {here, va[PageShift + LevelBits * (lvl - 1) +: LevelBits]},
                  table_entry(frame, present, huge), 48'({$urandom, $urandom}));
      end
      here = nxt;
    end
    // Walk the chain one to three times, each with a random page offset.
    walks = $urandom_range(1, 3);
    repeat (walks) begin
      va[11:0] = 12'($urandom);
      send_item(FUNC_XLATE, 13'($urandom), {$urandom, $urandom}, va);
    end
  endtask

  // Result checking against the oldest outstanding expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_taken++;
      seen_res.phys   = m_axis_tdata[51:0];
      seen_res.status = status_e'(m_axis_tdata[53:52]);
      if (walk_result_q.size() == 0) begin
        report_mismatch($sformatf("result transfer with nothing outstanding, phys %h",
                                  seen_res.phys));
      end else begin
        want_res = walk_result_q.pop_front();
        if (seen_res.status !== want_res.status) begin
          report_mismatch($sformatf("status %s, expected %s", seen_res.status.name(),
                                    want_res.status.name()));
        end
        if (seen_res.phys !== want_res.phys) begin
          report_mismatch($sformatf("phys_addr %h, expected %h", seen_res.phys,
                                    want_res.phys));
        end
      end
    end
  end

  // Receiver: a sequence of randomly chosen stall patterns, plus one long hold-off.
  initial begin
    int rx_mode;
    int mode_left;
    int hold_left;
    bit hold_done;
    rx_mode       = 0;
    mode_left     = 0;
    hold_left     = 0;
    hold_done     = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (!hold_done && results_taken >= HoldAfter) begin
        // Hold off long enough for the walker to fill up and stall its input.
        hold_done = 1'b1;
        hold_left = LongHold - 1;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= (mode_left % 3 == 0);
        endcase
      end
    end
  end

  // Main sequence: reset, directed rows, random phases under several root pages.
  initial begin
    logic [3:0] phase_root;
    int         phase_end;
    int         pick;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    error_count   = 0;
    results_taken = 0;
    items_sent    = 0;
    burst_left    = 0;
    root_mirror   = '0;
    foreach (table_mirror[i]) table_mirror[i] = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows; the first transfer waits out the clearing pass.
    foreach (DirectedRows[i]) begin
      send_item(DirectedRows[i].kind, DirectedRows[i].widx, DirectedRows[i].wval,
                DirectedRows[i].va, DirectedRows[i].typed, DirectedRows[i].want);
    end

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0, 4:    phase_root = 4'd15;
        1:       phase_root = 4'd0;
        default: phase_root = 4'($urandom_range(1, 14));
      endcase
      set_root(phase_root);
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          run_chain_episode();
        end else if (pick < 85) begin
          send_item(FUNC_WRITE, 13'($urandom), {$urandom, $urandom},
                    48'({$urandom, $urandom}));
        end else begin
          send_item(FUNC_XLATE, 13'($urandom), {$urandom, $urandom},
                    48'({$urandom, $urandom}));
        end
      end
    end

    drain_walker();
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0 && walk_result_q.size() == 0) begin
      $display("PASS four_level_page_table_walk_core");
    end else begin
      $display("FAIL four_level_page_table_walk_core");
    end
    $finish;
  end

  // Run limit: clearing pass plus about 1900 items at their slowest, several times over.
  initial begin
    #10_000_000;
    $display("FAIL four_level_page_table_walk_core");
    $finish;
  end

endmodule
